// File: hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants for the circular byte deque.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned BYTE_W = 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    action_e           action;
    logic [BYTE_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    status_e           status;
    logic              now_empty;
    logic              now_full;
  } out_t;

  // per-transaction result of the pointer engine, waiting for read data
  typedef struct packed {
    logic    rd;
    status_e status;
    logic    now_empty;
    logic    now_full;
  } info_t;

  function automatic idx_t wrap_next(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic idx_t wrap_prev(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// File: hdl/cbd_ram.sv
// ----------------------------------------------------------------------------
// cbd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int unsigned Depth  = 128,
  parameter int unsigned Width  = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cbd_ctrl.sv
// ----------------------------------------------------------------------------
// cbd_ctrl
// Head/tail pointer engine: decodes one operation, drives the slot RAM and
// updates the pointers and empty flag.
// ----------------------------------------------------------------------------
module cbd_ctrl
  import cbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  in_t               req_i,
  output logic              we_o,
  output idx_t              waddr_o,
  output logic [BYTE_W-1:0] wdata_o,
  output logic              re_o,
  output idx_t              raddr_o,
  output info_t             info_o
);

  idx_t head_q, head_d;
  idx_t tail_q, tail_d;
  logic empty_q, empty_d;
  logic full;
  logic pop_ok;
  status_e status;

  assign full = !empty_q && (wrap_next(tail_q) == head_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    status  = ST_DONE;
    pop_ok  = 1'b0;
    we_o    = 1'b0;
    waddr_o = '0;
    re_o    = 1'b0;
    raddr_o = head_q;
    case (req_i.action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else if (empty_q) begin
          // first element always lands in slot zero
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          we_o    = acc_i;
          waddr_o = '0;
        end else if (req_i.action == ACT_PUSH_FRONT) begin
          head_d  = wrap_prev(head_q);
          we_o    = acc_i;
          waddr_o = head_d;
        end else begin
          tail_d  = wrap_next(tail_q);
          we_o    = acc_i;
          waddr_o = tail_d;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (empty_q) begin
          status = ST_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          re_o    = acc_i;
          raddr_o = (req_i.action == ACT_POP_FRONT) ? head_q : tail_q;
          if (head_q == tail_q) begin
            empty_d = 1'b1;
            head_d  = '0;
            tail_d  = '0;
          end else if (req_i.action == ACT_POP_FRONT) begin
            head_d = wrap_next(head_q);
          end else begin
            tail_d = wrap_prev(tail_q);
          end
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign wdata_o          = req_i.data_in;
  assign info_o.rd        = pop_ok;
  assign info_o.status    = status;
  assign info_o.now_empty = empty_d;
  assign info_o.now_full  = !empty_d && (wrap_next(tail_d) == head_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (acc_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

endmodule

// File: hdl/circular_byte_deque.sv
// ----------------------------------------------------------------------------
// circular_byte_deque
// Double-ended byte queue held in a circular slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one operation per
//   transaction: push front, push rear, pop front or pop rear, plus a byte.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per operation: popped byte, status and empty/full flags.
//   Path: on acceptance the pointers update and the slot RAM is read into
//   the pending stage; the result is then registered in the output register,
//   and a stall can hold it in either of the two.
//   Throughput: one operation per cycle while the receiver keeps up; the
//   pointers update on acceptance, so back-to-back operations see the new
//   state, and the RAM read port is used at most once per operation.
//   Reset: the deque is empty and both pointers are at slot zero; no RAM
//   clearing is needed.
//   Stall: when out_ready_i is low the output register and one pending stage
//   hold their contents; in_ready_o drops once both are occupied.
// ----------------------------------------------------------------------------
module circular_byte_deque
  import cbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic              acc;
  logic              we;
  idx_t              waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  idx_t              raddr;
  logic [BYTE_W-1:0] rdata;
  info_t             info;

  logic  s1_valid_q, s1_valid_d;
  info_t s1_q;
  logic  s1_adv;
  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;

  cbd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .req_i   (in_data_i),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .info_o  (info)
  );

  cbd_ram #(
    .Depth (DEPTH),
    .Width (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d         = acc || (s1_valid_q && !s1_adv);
    out_valid_d        = s1_adv || (out_valid_q && !out_ready_i);
    out_d.data_out     = s1_q.rd ? rdata : '0;
    out_d.status       = s1_q.status;
    out_d.now_empty    = s1_q.now_empty;
    out_d.now_full     = s1_q.now_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= info;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
